>>> rtl/kced_pkg.sv
// ----------------------------------------------------------------------------
// Key click event detector package
// Shared widths, register indexes, reset values, phase and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kced_pkg;

	localparam int KEY_W  = 3;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int EV_W   = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd1;
	localparam logic [IDX_W-1:0] REG_DOUBLE_GAP = 3'd2;
	localparam logic [IDX_W-1:0] REG_REPEAT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_DOUBLE_EN  = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd20;
	localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd1000;
	localparam logic [CFG_W-1:0] RST_DOUBLE_GAP = 16'd300;
	localparam logic [CFG_W-1:0] RST_REPEAT     = 16'd200;
	localparam logic             RST_DOUBLE_EN  = 1'b1;

	// Event codes returned for each poll.
	typedef enum logic [EV_W-1:0] {
		EV_NONE      = 3'd0,
		EV_PRESS     = 3'd1,
		EV_SINGLE    = 3'd2,
		EV_LONG_HELD = 3'd3,
		EV_LONG_REL  = 3'd4,
		EV_DOUBLE    = 3'd5,
		EV_SL_HELD   = 3'd6,
		EV_SL_REL    = 3'd7
	} event_t;

	// Detector phases, one-hot.
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_DEB1 = 6'b000010,
		PH_PRS1 = 6'b000100,
		PH_REL1 = 6'b001000,
		PH_DEB2 = 6'b010000,
		PH_PRS2 = 6'b100000
	} phase_t;

	// Configuration as seen by the detector.
	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] double_gap_ms;
		logic [CFG_W-1:0] repeat_ms;
		logic             double_enable;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/kced_if.sv
// ----------------------------------------------------------------------------
// Key click event detector channels
// Valid/ready interfaces for polls, events and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Poll channel: one sampled key code and timestamp per request.
interface kced_poll_if;
	logic                          valid;
	logic                          ready;
	logic [kced_pkg::KEY_W-1:0]    key_code;
	logic [kced_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output key_code, output now_ms, input ready);
	modport sink   (input valid, input key_code, input now_ms, output ready);
endinterface

// Event channel: one event code and key id per request.
interface kced_event_if;
	logic                          valid;
	logic                          ready;
	logic [kced_pkg::EV_W-1:0]     event_res;
	logic [kced_pkg::KEY_W-1:0]    event_key;

	modport source (output valid, output event_res, output event_key, input ready);
	modport sink   (input valid, input event_res, input event_key, output ready);
endinterface

// Configuration write channel.
interface kced_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kced_pkg::IDX_W-1:0]    index;
	logic [kced_pkg::CFG_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/kced_fsm.sv
// ----------------------------------------------------------------------------
// Key click event detector state machine
// Holds the phase and time stamps and works out the event for one poll.
// ----------------------------------------------------------------------------
`default_nettype none

module kced_fsm (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [kced_pkg::KEY_W-1:0]  key,
	input  wire logic [kced_pkg::TIME_W-1:0] now,
	input  wire kced_pkg::cfg_t              cfg,
	output kced_pkg::event_t                 ev,
	output logic [kced_pkg::KEY_W-1:0]       ek
);
	import kced_pkg::*;

	phase_t              phase_q, phase_d;
	logic [KEY_W-1:0]    held_key_q, held_key_d;
	logic [TIME_W-1:0]   deb_stamp_q, deb_stamp_d;
	logic [TIME_W-1:0]   press_stamp_q, press_stamp_d;
	logic [TIME_W-1:0]   rel_stamp_q, rel_stamp_d;
	logic [TIME_W-1:0]   rep_off_q, rep_off_d;

	logic [TIME_W-1:0]   dt_deb, dt_press, dt_rel;
	logic                deb_done, is_long, gap_done, rep_due, key_on;
	logic [TIME_W:0]     rep_limit, rep_sum;
	logic [TIME_W-1:0]   rep_next;
	event_t              ev_raw;

	// Elapsed times wrap modulo 2^32; a time has passed only when strictly exceeded.
	assign dt_deb    = now - deb_stamp_q;
	assign dt_press  = now - press_stamp_q;
	assign dt_rel    = now - rel_stamp_q;
	assign deb_done  = dt_deb > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
	assign is_long   = dt_press > {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
	assign gap_done  = dt_rel > {{(TIME_W-CFG_W){1'b0}}, cfg.double_gap_ms};
	assign key_on    = key != '0;

	// Repeat threshold and the saturating step of the repeat offset.
	assign rep_limit = {{(TIME_W+1-CFG_W){1'b0}}, cfg.long_press_ms} + {1'b0, rep_off_q};
	assign rep_due   = {1'b0, dt_press} > rep_limit;
	assign rep_sum   = {1'b0, rep_off_q} + {{(TIME_W+1-CFG_W){1'b0}}, cfg.repeat_ms};
	assign rep_next  = rep_sum[TIME_W] ? '1 : rep_sum[TIME_W-1:0];

	// Next state and event for the poll being processed.
	always_comb begin
		phase_d       = phase_q;
		held_key_d    = held_key_q;
		deb_stamp_d   = deb_stamp_q;
		press_stamp_d = press_stamp_q;
		rel_stamp_d   = rel_stamp_q;
		rep_off_d     = rep_off_q;
		ev_raw        = EV_NONE;
		ek            = held_key_q;
		case (phase_q)
			PH_IDLE: begin
				ek = '0;
				if (key_on) begin
					phase_d     = PH_DEB1;
					deb_stamp_d = now;
				end
			end
			PH_DEB1: begin
				ek = key;
				if (deb_done) begin
					if (key_on) begin
						phase_d       = PH_PRS1;
						press_stamp_d = now;
						held_key_d    = key;
						ev_raw        = EV_PRESS;
					end else begin
						phase_d    = PH_IDLE;
						held_key_d = '0;
					end
				end
			end
			PH_PRS1, PH_PRS2: begin
				if (is_long) begin
					if (!key_on) begin
						phase_d    = PH_IDLE;
						held_key_d = '0;
						rep_off_d  = '0;
						ev_raw     = (phase_q == PH_PRS1) ? EV_LONG_REL : EV_SL_REL;
					end else if (rep_due) begin
						rep_off_d = rep_next;
						ev_raw    = (phase_q == PH_PRS1) ? EV_LONG_HELD : EV_SL_HELD;
					end
				end else if (!key_on) begin
					if (phase_q == PH_PRS1) begin
						phase_d     = PH_REL1;
						rel_stamp_d = now;
					end else begin
						phase_d    = PH_IDLE;
						held_key_d = '0;
						ev_raw     = EV_DOUBLE;
					end
				end
			end
			PH_REL1: begin
				if (cfg.double_enable) begin
					if (key_on) begin
						deb_stamp_d = now;
						phase_d     = PH_DEB2;
					end else if (gap_done) begin
						ev_raw     = EV_SINGLE;
						phase_d    = PH_IDLE;
						held_key_d = '0;
					end
				end else begin
					ev_raw     = EV_SINGLE;
					phase_d    = PH_IDLE;
					held_key_d = '0;
				end
			end
			PH_DEB2: begin
				if (deb_done) begin
					if (key_on) begin
						phase_d       = PH_PRS2;
						press_stamp_d = now;
						held_key_d    = key;
					end else begin
						ev_raw     = EV_SINGLE;
						phase_d    = PH_IDLE;
						held_key_d = '0;
					end
				end
			end
			default: begin
				// An illegal phase returns everything to its reset value.
				phase_d       = PH_IDLE;
				held_key_d    = '0;
				deb_stamp_d   = '0;
				press_stamp_d = '0;
				rel_stamp_d   = '0;
				rep_off_d     = '0;
			end
		endcase
		ev = ev_raw;
		if (ev_raw == EV_NONE) begin
			ek = '0;
		end
	end

	// State registers advance once per processed poll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			held_key_q    <= '0;
			deb_stamp_q   <= '0;
			press_stamp_q <= '0;
			rel_stamp_q   <= '0;
			rep_off_q     <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			held_key_q    <= held_key_d;
			deb_stamp_q   <= deb_stamp_d;
			press_stamp_q <= press_stamp_d;
			rel_stamp_q   <= rel_stamp_d;
			rep_off_q     <= rep_off_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/key_click_event_detector_top.sv
// ----------------------------------------------------------------------------
// Key click event detector
// Debounces a polled key and reports press, click, double and long events.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the poll channel carries the sampled key code (0 for no
// key) and the current millisecond timestamp. Every poll produces exactly
// one request on the event channel: the event code and the latched key id.
// The cfg channel writes the five timing and enable registers; it is always
// ready and should only be used while no poll is in flight.
// A poll is held in an input register and evaluated against the stored
// stamps by the detector into the result register, from which its event
// is offered on the event channel. One poll per cycle is sustained while
// the event receiver keeps ready high; the detector updates its state
// once per poll.
// If the event receiver stalls, the result is held and poll ready falls
// once the input register holds a poll.
// Reset clears the detector to idle, empties both registers and restores
// the default timing and enable values.
// ----------------------------------------------------------------------------
`default_nettype none

module key_click_event_detector_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kced_poll_if.sink  poll,
	kced_event_if.source evt,
	kced_cfg_if.sink   cfg
);
	import kced_pkg::*;

	cfg_t                cfg_q;
	logic                vld_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                vld_s2;
	event_t              ev_s2;
	logic [KEY_W-1:0]    ek_s2;
	logic                advance;
	event_t              ev;
	logic [KEY_W-1:0]    ek;

	// Configuration writes; indexes beyond the register list are ignored.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= RST_DEBOUNCE;
			cfg_q.long_press_ms <= RST_LONG_PRESS;
			cfg_q.double_gap_ms <= RST_DOUBLE_GAP;
			cfg_q.repeat_ms     <= RST_REPEAT;
			cfg_q.double_enable <= RST_DOUBLE_EN;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg.data;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg.data;
				REG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg.data;
				REG_REPEAT:     cfg_q.repeat_ms     <= cfg.data;
				REG_DOUBLE_EN:  cfg_q.double_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// The held poll moves on whenever the result register is free or emptying.
	assign advance    = !vld_s2 || evt.ready;
	assign poll.ready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (poll.ready) begin
			vld_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			key_s1 <= poll.key_code;
			now_s1 <= poll.now_ms;
		end
	end

	// Detector state machine.
	kced_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (vld_s1 && advance),
		.key    (key_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.ev     (ev),
		.ek     (ek)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			ev_s2 <= ev;
			ek_s2 <= ek;
		end
	end

	assign evt.valid     = vld_s2;
	assign evt.event_res = ev_s2;
	assign evt.event_key = ek_s2;

endmodule

`default_nettype wire
